### rtl/vacu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve aperture command unit package
// Widths, codes, state types, control structs and the constant tables shared
// by the valve aperture command unit and its serial arithmetic.
// ----------------------------------------------------------------------------
package vacu_pkg;

  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned SECTION_W   = 32;
  localparam int unsigned EST_W       = 13;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SECT_W      = 12;
  localparam int unsigned SQ_W        = 17;
  localparam int unsigned TERM_W      = 16;

  // Serial arithmetic unit.
  localparam int unsigned ALU_W       = 32;
  localparam int unsigned ALU_B_W     = 17;
  localparam int unsigned ALU_CNT_W   = 5;
  localparam int unsigned MUL_STEPS   = 17;
  localparam int unsigned DIV_STEPS   = 32;

  // Reset values of the angle registers.
  localparam logic [CFG_W-1:0] OPEN_RESET  = 7'd0;
  localparam logic [CFG_W-1:0] CLOSE_RESET = 7'd125;

  // Section fit constants.
  localparam int unsigned SECT_MAX    = 3318;
  localparam int unsigned SECT_KNEE   = 1960;
  localparam int unsigned SHORT_BASE  = 98;
  localparam int unsigned SHORT_SLOPE = 318;
  localparam int unsigned SHORT_DIV   = 10000;
  localparam int unsigned SQ_DIV      = 100;
  localparam int unsigned CUBE_BASE   = 2626;
  localparam int unsigned LIN_SLOPE   = 36;
  localparam int unsigned LIN_DIV     = 10;
  localparam int unsigned QUAD_COEF   = 168;
  localparam int unsigned QUAD_DIV    = 1000;
  localparam int unsigned CUBE_DIV    = 100;
  localparam int unsigned CUBE_COEF   = 264;
  localparam int unsigned CUBE_SCALE  = 100000;

  // Table sizes.
  localparam int unsigned LIN_DEPTH   = 128;
  localparam int unsigned EST_DEPTH   = 106;
  localparam int unsigned EST_LAST    = 105;

  typedef enum logic [OPCODE_W-1:0] {
    OP_OPEN    = 3'd0,
    OP_CLOSE   = 3'd1,
    OP_RAW     = 3'd2,
    OP_SECTION = 3'd3,
    OP_LINEAR  = 3'd4,
    OP_QUERY   = 3'd5
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_ANGLE  = 2'd0,
    CFG_CLOSE_ANGLE = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } unit_state_e;

  typedef enum logic [3:0] {
    SEC_IDLE,
    SEC_SHORT_MUL,
    SEC_SHORT_DIV,
    SEC_SQ_MUL,
    SEC_SQ_DIV,
    SEC_LIN_MUL,
    SEC_LIN_DIV,
    SEC_QUAD_MUL,
    SEC_QUAD_DIV,
    SEC_CUBE_MUL,
    SEC_CUBE_DIV,
    SEC_SCALE_MUL,
    SEC_SCALE_DIV,
    SEC_DONE
  } sec_state_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              start;
    logic [SECT_W-1:0] sect;
  } sec_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] angle;
  } sec_rsp_t;

  // Linearisation result, before the final clamp, for every clamped angle.
  // The arithmetic wraps at 32 bits on purpose.
  function automatic logic [LIN_DEPTH*ANGLE_W-1:0] build_lin_tab();
    logic [LIN_DEPTH*ANGLE_W-1:0] tab;
    logic [31:0] v;
    logic [31:0] r;
    logic [31:0] p;
    tab = '0;
    for (int i = 0; i < LIN_DEPTH; i++) begin
      v = ((32'(i) * 32'd75) / 32'd125 + 32'd30) * 32'd10;
      r = (32'd76 * v) / 32'd10;
      r = r - ((32'd985 * v) * v) / 32'd100000;
      p = ((32'd44 * v) * v) / 32'd1000;
      r = r + (p * v) / 32'd10000;
      r = r - 32'd1140;
      r = r / 32'd10;
      tab[i*ANGLE_W +: ANGLE_W] = r[ANGLE_W-1:0];
    end
    return tab;
  endfunction

  // Flow section estimate for commands up to the last table entry; larger
  // commands estimate zero.
  function automatic logic [EST_DEPTH*EST_W-1:0] build_est_tab();
    logic [EST_DEPTH*EST_W-1:0] tab;
    int s;
    tab = '0;
    for (int c = 0; c < EST_DEPTH; c++) begin
      if (c >= 50) begin
        s = 5760 - (558 * c) / 10;
      end else begin
        s = 4390 - 5 * c - (47 * c * c) / 100;
      end
      if (s < 0) begin
        s = 0;
      end
      tab[c*EST_W +: EST_W] = EST_W'(s);
    end
    return tab;
  endfunction

  localparam logic [LIN_DEPTH*ANGLE_W-1:0] LIN_TAB = build_lin_tab();
  localparam logic [EST_DEPTH*EST_W-1:0]   EST_TAB = build_est_tab();

  function automatic logic [ANGLE_W-1:0] clamp_angle(
    input logic [ANGLE_W-1:0] val,
    input logic [CFG_W-1:0]   lo,
    input logic [CFG_W-1:0]   hi
  );
    logic [ANGLE_W-1:0] lo_w;
    logic [ANGLE_W-1:0] hi_w;
    logic [ANGLE_W-1:0] res;
    lo_w = ANGLE_W'(lo);
    hi_w = ANGLE_W'(hi);
    if (val < lo_w) begin
      res = lo_w;
    end else if (val > hi_w) begin
      res = hi_w;
    end else begin
      res = val;
    end
    return res;
  endfunction

endpackage

### rtl/vacu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve aperture command unit channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface vacu_in_if;
  import vacu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [ANGLE_W-1:0]   angle_request;
  logic [SECTION_W-1:0] section_request;

  modport source (
    output valid, opcode, angle_request, section_request,
    input  ready
  );

  modport sink (
    input  valid, opcode, angle_request, section_request,
    output ready
  );
endinterface

interface vacu_out_if;
  import vacu_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] command_angle;
  logic [ANGLE_W-1:0] linear_position;
  logic [EST_W-1:0]   section_estimate;

  modport source (
    output valid, command_angle, linear_position, section_estimate,
    input  ready
  );

  modport sink (
    input  valid, command_angle, linear_position, section_estimate,
    output ready
  );
endinterface

### rtl/vacu_serial_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiply/divide unit
// Shift-and-add multiply, one multiplier bit per cycle, and restoring divide,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vacu_serial_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vacu_pkg::alu_req_t         req_i,
  input  logic [vacu_pkg::ALU_W-1:0] opa_i,
  input  logic [vacu_pkg::ALU_B_W-1:0] opb_i,
  output logic                       done_o,
  output logic [vacu_pkg::ALU_W-1:0] result_o
);
  import vacu_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  alu_op_e              op_q, op_d;
  logic [ALU_CNT_W-1:0] cnt_q, cnt_d;
  logic [ALU_W-1:0]     acc_q, acc_d;
  // Multiplicand when multiplying; dividend shifting out and quotient
  // shifting in when dividing.
  logic [ALU_W-1:0]     sh_q, sh_d;
  // Multiplier bits when multiplying; divisor when dividing.
  logic [ALU_B_W-1:0]   b_q, b_d;
  logic [ALU_B_W:0]     rem_q, rem_d;
  logic [ALU_B_W:0]     rem_sh;
  logic                 fits;

  assign rem_sh = {rem_q[ALU_B_W-1:0], sh_q[ALU_W-1]};
  assign fits   = (rem_sh >= {1'b0, b_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    rem_d  = rem_q;
    if (busy_q) begin
      unique case (op_q)
        ALU_MUL: begin
          if (b_q[0]) begin
            acc_d = acc_q + sh_q;
          end
          sh_d = {sh_q[ALU_W-2:0], 1'b0};
          b_d  = {1'b0, b_q[ALU_B_W-1:1]};
        end
        ALU_DIV: begin
          rem_d = fits ? (rem_sh - {1'b0, b_q}) : rem_sh;
          sh_d  = {sh_q[ALU_W-2:0], fits};
        end
        default: ;
      endcase
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = '0;
      rem_d  = '0;
      sh_d   = opa_i;
      b_d    = opb_i;
      cnt_d  = (req_i.op == ALU_MUL) ? ALU_CNT_W'(MUL_STEPS - 1)
                                     : ALU_CNT_W'(DIV_STEPS - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == ALU_MUL) ? acc_q : sh_q;

endmodule

### rtl/vacu_section_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Section fit sequencer
// Steps the piecewise section-to-angle fit through the serial multiply/divide
// unit and clamps the result to the configured angle range.
// ----------------------------------------------------------------------------
module vacu_section_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vacu_pkg::sec_req_t         req_i,
  input  logic [vacu_pkg::CFG_W-1:0] lo_i,
  input  logic [vacu_pkg::CFG_W-1:0] hi_i,
  output vacu_pkg::sec_rsp_t         rsp_o
);
  import vacu_pkg::*;

  sec_state_e               state_q, state_d;
  logic                     issued_q, issued_d;
  logic [SECT_W-1:0]        s_q, s_d;
  logic [SQ_W-1:0]          sq_q, sq_d;
  logic signed [TERM_W-1:0] t_q, t_d;
  logic signed [TERM_W-1:0] quo;
  logic signed [TERM_W-1:0] lo_s;
  logic signed [TERM_W-1:0] hi_s;

  alu_req_t                 alu_req;
  logic [ALU_W-1:0]         alu_opa;
  logic [ALU_B_W-1:0]       alu_opb;
  logic                     alu_done;
  logic [ALU_W-1:0]         alu_result;

  vacu_serial_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .opa_i    (alu_opa),
    .opb_i    (alu_opb),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // Every quotient added into the fit term stays well below 2^15.
  assign quo  = $signed(alu_result[TERM_W-1:0]);
  assign lo_s = $signed(TERM_W'(lo_i));
  assign hi_s = $signed(TERM_W'(hi_i));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEC_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.sect < SECT_W'(SECT_KNEE)) ? SEC_SHORT_MUL : SEC_SQ_MUL;
        end
      end
      SEC_SHORT_MUL: if (alu_done) state_d = SEC_SHORT_DIV;
      SEC_SHORT_DIV: if (alu_done) state_d = SEC_DONE;
      SEC_SQ_MUL:    if (alu_done) state_d = SEC_SQ_DIV;
      SEC_SQ_DIV:    if (alu_done) state_d = SEC_LIN_MUL;
      SEC_LIN_MUL:   if (alu_done) state_d = SEC_LIN_DIV;
      SEC_LIN_DIV:   if (alu_done) state_d = SEC_QUAD_MUL;
      SEC_QUAD_MUL:  if (alu_done) state_d = SEC_QUAD_DIV;
      SEC_QUAD_DIV:  if (alu_done) state_d = SEC_CUBE_MUL;
      SEC_CUBE_MUL:  if (alu_done) state_d = SEC_CUBE_DIV;
      SEC_CUBE_DIV:  if (alu_done) state_d = SEC_SCALE_MUL;
      SEC_SCALE_MUL: if (alu_done) state_d = SEC_SCALE_DIV;
      SEC_SCALE_DIV: if (alu_done) state_d = SEC_DONE;
      SEC_DONE:      state_d = SEC_IDLE;
      default:       state_d = SEC_IDLE;
    endcase
  end

  // Outputs: operation and operands for the serial unit, and the response.
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    rsp_o.done    = 1'b0;
    rsp_o.angle   = '0;
    unique case (state_q)
      SEC_SHORT_MUL: begin
        alu_opa = ALU_W'(SHORT_SLOPE);
        alu_opb = ALU_B_W'(s_q);
      end
      SEC_SHORT_DIV: begin
        alu_req.op = ALU_DIV;
        alu_opa    = alu_result;
        alu_opb    = ALU_B_W'(SHORT_DIV);
      end
      SEC_SQ_MUL: begin
        alu_opa = ALU_W'(s_q);
        alu_opb = ALU_B_W'(s_q);
      end
      SEC_SQ_DIV: begin
        alu_req.op = ALU_DIV;
        alu_opa    = alu_result;
        alu_opb    = ALU_B_W'(SQ_DIV);
      end
      SEC_LIN_MUL: begin
        alu_opa = ALU_W'(LIN_SLOPE);
        alu_opb = ALU_B_W'(s_q);
      end
      SEC_LIN_DIV: begin
        alu_req.op = ALU_DIV;
        alu_opa    = alu_result;
        alu_opb    = ALU_B_W'(LIN_DIV);
      end
      SEC_QUAD_MUL: begin
        alu_opa = ALU_W'(QUAD_COEF);
        alu_opb = sq_q;
      end
      SEC_QUAD_DIV: begin
        alu_req.op = ALU_DIV;
        alu_opa    = alu_result;
        alu_opb    = ALU_B_W'(QUAD_DIV);
      end
      SEC_CUBE_MUL: begin
        alu_opa = ALU_W'(s_q);
        alu_opb = sq_q;
      end
      SEC_CUBE_DIV: begin
        alu_req.op = ALU_DIV;
        alu_opa    = alu_result;
        alu_opb    = ALU_B_W'(CUBE_DIV);
      end
      SEC_SCALE_MUL: begin
        // The scaled cube term is too wide for the serial operand, so the
        // small coefficient goes there instead.
        alu_opa = alu_result;
        alu_opb = ALU_B_W'(CUBE_COEF);
      end
      SEC_SCALE_DIV: begin
        alu_req.op = ALU_DIV;
        alu_opa    = alu_result;
        alu_opb    = ALU_B_W'(CUBE_SCALE);
      end
      SEC_DONE: begin
        rsp_o.done = 1'b1;
        if (t_q < lo_s) begin
          rsp_o.angle = lo_i;
        end else if (t_q > hi_s) begin
          rsp_o.angle = hi_i;
        end else begin
          rsp_o.angle = t_q[CFG_W-1:0];
        end
      end
      default: ;
    endcase
    alu_req.start = (state_q != SEC_IDLE) && (state_q != SEC_DONE) && !issued_q;
  end

  // Partial results of the fit.
  always_comb begin
    s_d      = s_q;
    sq_d     = sq_q;
    t_d      = t_q;
    issued_d = issued_q;
    if (alu_done) begin
      issued_d = 1'b0;
    end else if (alu_req.start) begin
      issued_d = 1'b1;
    end
    if ((state_q == SEC_IDLE) && req_i.start) begin
      s_d = req_i.sect;
    end
    if (alu_done) begin
      unique case (state_q)
        SEC_SHORT_DIV: t_d = $signed(TERM_W'(SHORT_BASE)) - quo;
        SEC_SQ_DIV:    sq_d = alu_result[SQ_W-1:0];
        SEC_LIN_DIV:   t_d = $signed(TERM_W'(CUBE_BASE)) - quo;
        SEC_QUAD_DIV:  t_d = t_q + quo;
        SEC_SCALE_DIV: t_d = t_q - quo;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEC_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q  <= s_d;
    sq_q <= sq_d;
    t_q  <= t_d;
  end

endmodule

### rtl/valve_aperture_command_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve aperture command unit
// Holds the valve angle command and turns open, close, raw, section and
// linear requests into it; every request word returns one result word.
// ----------------------------------------------------------------------------
// Open, close, raw, linear and query words take effect on acceptance, then
// pass through the emit state into the output register. Section words run the fit
// through the serial multiply/divide unit: a multiply and a divide below the knee,
// the square, linear, quadratic, cube and scale steps above it. A new word waits
// until the last result is in the output register. Reset is asynchronous, active
// low, and loads open 0, close 125, the command 125 and the linear position 0.
module valve_aperture_command_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vacu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vacu_pkg::CFG_W-1:0]     cfg_data_i,
  vacu_in_if.sink                        in_i,
  vacu_out_if.source                     out_o
);
  import vacu_pkg::*;

  unit_state_e        state_q, state_d;
  logic [CFG_W-1:0]   open_q;
  logic [CFG_W-1:0]   close_q;
  logic [ANGLE_W-1:0] cmd_q, cmd_d;
  logic [ANGLE_W-1:0] lin_q, lin_d;
  logic               out_valid_q, out_valid_d;
  logic [ANGLE_W-1:0] out_cmd_q;
  logic [ANGLE_W-1:0] out_lin_q;
  logic [EST_W-1:0]   out_est_q;
  logic               out_load;

  logic [CFG_W-1:0]   lo;
  logic [CFG_W-1:0]   hi;
  logic               accept;
  logic [SECT_W-1:0]  sect_clamped;
  logic [ANGLE_W-1:0] lin_clamped;
  logic [ANGLE_W-1:0] lin_raw;
  logic [EST_W-1:0]   est;

  sec_req_t           sec_req;
  sec_rsp_t           sec_rsp;

  vacu_section_seq u_section (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sec_req),
    .lo_i   (lo),
    .hi_i   (hi),
    .rsp_o  (sec_rsp)
  );

  assign lo = (open_q < close_q) ? open_q : close_q;
  assign hi = (open_q < close_q) ? close_q : open_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Negative requests go to zero, large ones to the top of the fit.
  always_comb begin
    if (in_i.section_request[SECTION_W-1]) begin
      sect_clamped = '0;
    end else if (in_i.section_request > SECTION_W'(SECT_MAX)) begin
      sect_clamped = SECT_W'(SECT_MAX);
    end else begin
      sect_clamped = in_i.section_request[SECT_W-1:0];
    end
  end

  // The clamped linear angle never exceeds the 7-bit range, so its low bits
  // index the linearisation table directly.
  assign lin_clamped = clamp_angle(in_i.angle_request, lo, hi);
  assign lin_raw     = LIN_TAB[int'(lin_clamped[CFG_W-1:0]) * ANGLE_W +: ANGLE_W];

  assign est = (cmd_q <= ANGLE_W'(EST_LAST))
             ? EST_TAB[int'(cmd_q[CFG_W-1:0]) * EST_W +: EST_W]
             : '0;

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.opcode == OP_SECTION) ? ST_RUN : ST_EMIT;
        end
      end
      ST_RUN: begin
        if (sec_rsp.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and command updates.
  always_comb begin
    sec_req.start = 1'b0;
    sec_req.sect  = sect_clamped;
    cmd_d         = cmd_q;
    lin_d         = lin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.opcode)
            OP_OPEN:    cmd_d = ANGLE_W'(open_q);
            OP_CLOSE:   cmd_d = ANGLE_W'(close_q);
            OP_RAW:     cmd_d = in_i.angle_request;
            OP_SECTION: sec_req.start = 1'b1;
            OP_LINEAR: begin
              lin_d = lin_clamped;
              cmd_d = clamp_angle(lin_raw, lo, hi);
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (sec_rsp.done) begin
          cmd_d = ANGLE_W'(sec_rsp.angle);
        end
      end
      default: ;
    endcase
  end

  // The output register holds a finished word while the next one is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      open_q      <= OPEN_RESET;
      close_q     <= CLOSE_RESET;
      cmd_q       <= ANGLE_W'(CLOSE_RESET);
      lin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      lin_q       <= lin_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == CFG_OPEN_ANGLE)) begin
        open_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == CFG_CLOSE_ANGLE)) begin
        close_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cmd_q <= cmd_q;
      out_lin_q <= lin_q;
      out_est_q <= est;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.command_angle    = out_cmd_q;
  assign out_o.linear_position  = out_lin_q;
  assign out_o.section_estimate = out_est_q;

endmodule

### verif/valve_aperture_command_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve aperture command unit testbench
// Drives request words through the valve aperture command unit under several
// angle settings and handshake idling profiles. A scoreboard predicts each
// result word from its own model of the command and linear position, and
// compares every received result word field by field.
// ----------------------------------------------------------------------------
import vacu_pkg::*;

typedef struct {
  logic [ANGLE_W-1:0] command_angle;
  logic [ANGLE_W-1:0] linear_position;
  logic [EST_W-1:0]   section_estimate;
} valve_result_t;

class valve_scoreboard;
  logic [CFG_W-1:0]   open_angle;
  logic [CFG_W-1:0]   close_angle;
  logic [ANGLE_W-1:0] command_angle;
  logic [ANGLE_W-1:0] linear_position;
  valve_result_t      expected_results[$];
  int unsigned        mismatches;
  int unsigned        checked;
  int unsigned        noted;
  int unsigned        op_count[8];

  function new();
    open_angle      = OPEN_RESET;
    close_angle     = CLOSE_RESET;
    command_angle   = ANGLE_W'(CLOSE_RESET);
    linear_position = '0;
    mismatches      = 0;
    checked         = 0;
    noted           = 0;
    foreach (op_count[i]) op_count[i] = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == CFG_OPEN_ANGLE) begin
      open_angle = data;
    end else if (idx == CFG_CLOSE_ANGLE) begin
      close_angle = data;
    end
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  function logic [ANGLE_W-1:0] bound(logic [ANGLE_W-1:0] val, int unsigned lo,
                                     int unsigned hi);
    if (val < lo) return ANGLE_W'(lo);
    if (val > hi) return ANGLE_W'(hi);
    return val;
  endfunction

  // Piecewise fit from a flow section (times 100) to a valve angle.
  function logic [ANGLE_W-1:0] section_angle(logic signed [SECTION_W-1:0] req,
                                             int unsigned lo, int unsigned hi);
    longint s;
    longint sq;
    longint t;
    s = req;
    if (s < 0) s = 0;
    if (s > 3318) s = 3318;
    if (s < 1960) begin
      t = 98 - (318 * s) / 10000;
    end else begin
      sq = (s * s) / 100;
      t = 2626 - (36 * s) / 10 + (168 * sq) / 1000 - (264 * ((sq * s) / 100)) / 100000;
    end
    if (t < longint'(lo)) t = lo;
    if (t > longint'(hi)) t = hi;
    return ANGLE_W'(t);
  endfunction

  // Cubic linearisation; the intermediate terms deliberately wrap at 32 bits.
  function logic [ANGLE_W-1:0] linear_command(logic [ANGLE_W-1:0] a, int unsigned lo,
                                              int unsigned hi);
    bit [31:0] v;
    bit [31:0] r;
    bit [31:0] p;
    v = ((32'(a) * 32'd75) / 32'd125 + 32'd30) * 32'd10;
    r = (32'd76 * v) / 32'd10;
    r = r - ((32'd985 * v) * v) / 32'd100000;
    p = ((32'd44 * v) * v) / 32'd1000;
    r = r + (p * v) / 32'd10000;
    r = r - 32'd1140;
    r = r / 32'd10;
    return bound(r[ANGLE_W-1:0], lo, hi);
  endfunction

  function logic [EST_W-1:0] flow_estimate(logic [ANGLE_W-1:0] cmd);
    int c;
    int s;
    c = cmd;
    if (c > 105) begin
      s = 0;
    end else if (c >= 50) begin
      s = 5760 - (558 * c) / 10;
    end else begin
      s = 4390 - 5 * c - (47 * c * c) / 100;
    end
    if (s < 0) s = 0;
    return EST_W'(s);
  endfunction

  function void note_word(logic [OPCODE_W-1:0] op, logic [ANGLE_W-1:0] ang,
                          logic [SECTION_W-1:0] sec);
    int unsigned   lo;
    int unsigned   hi;
    valve_result_t want;
    lo = (open_angle < close_angle) ? open_angle : close_angle;
    hi = (open_angle < close_angle) ? close_angle : open_angle;
    noted++;
    op_count[op]++;
    case (op)
      OP_OPEN:    command_angle = ANGLE_W'(open_angle);
      OP_CLOSE:   command_angle = ANGLE_W'(close_angle);
      OP_RAW:     command_angle = ang;
      OP_SECTION: command_angle = section_angle(sec, lo, hi);
      OP_LINEAR: begin
        linear_position = bound(ang, lo, hi);
        command_angle   = linear_command(linear_position, lo, hi);
      end
      default: ;
    endcase
    want.command_angle    = command_angle;
    want.linear_position  = linear_position;
    want.section_estimate = flow_estimate(command_angle);
    expected_results.push_back(want);
  endfunction

  function void check_word(valve_result_t got);
    valve_result_t want;
    checked++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: cmd %0d lin %0d est %0d",
                 got.command_angle, got.linear_position, got.section_estimate);
      return;
    end
    want = expected_results.pop_front();
    if (got.command_angle !== want.command_angle ||
        got.linear_position !== want.linear_position ||
        got.section_estimate !== want.section_estimate) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result word %0d: expected cmd %0d lin %0d est %0d, got cmd %0d lin %0d est %0d",
                 checked, want.command_angle, want.linear_position, want.section_estimate,
                 got.command_angle, got.linear_position, got.section_estimate);
    end
  endfunction
endclass

module valve_aperture_command_unit_tb;

  localparam logic [OPCODE_W-1:0]  OP_SPARE_A    = 3'd6;
  localparam logic [OPCODE_W-1:0]  OP_SPARE_B    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;
  localparam int unsigned          PHASE_WORDS   = 125;
  localparam int unsigned          SETTLE_CYCLES = 6;
  localparam int unsigned          QUIET_LIMIT   = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  vacu_in_if  in_if ();
  vacu_out_if out_if ();

  valve_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     hold_left;
  int unsigned     reg_writes;

  valve_aperture_command_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one request word, optionally after an idle gap, and returns once it
  // has been accepted. Valid stays high afterwards; the caller lowers it.
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [ANGLE_W-1:0] ang,
                           input logic [SECTION_W-1:0] sec);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid           <= 1'b1;
    in_if.opcode          <= op;
    in_if.angle_request   <= ang;
    in_if.section_request <= sec;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(op, ang, sec);
  endtask

  task automatic send_random_word();
    int unsigned          pick;
    logic [OPCODE_W-1:0]  op;
    logic [ANGLE_W-1:0]   ang;
    logic [SECTION_W-1:0] sec;
    pick = $urandom_range(0, 99);
    if (pick < 10)      op = OP_OPEN;
    else if (pick < 20) op = OP_CLOSE;
    else if (pick < 35) op = OP_RAW;
    else if (pick < 55) op = OP_SECTION;
    else if (pick < 85) op = OP_LINEAR;
    else if (pick < 93) op = OP_QUERY;
    else                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    ang = ($urandom_range(0, 99) < 70) ? ANGLE_W'($urandom_range(0, 127))
                                       : ANGLE_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: sec = $urandom_range(0, 1959);
      3, 4, 5: sec = $urandom_range(1960, 3318);
      6:       sec = $urandom_range(0, 1) ? $urandom_range(1957, 1963)
                                          : $urandom_range(3315, 3321);
      7:       sec = -$urandom_range(1, 5000);
      default: sec = $urandom;
    endcase
    send_word(op, ang, sec);
  endtask

  // The block only holds words in flight, so once every result is back it is
  // idle; the settle wait that follows covers its output register.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_angles(input logic [CFG_W-1:0] open_v, input logic [CFG_W-1:0] close_v,
                            input bit spare_too);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_OPEN_ANGLE;
    cfg_data_i  <= open_v;
    @(posedge clk_i);
    sb.write_register(CFG_OPEN_ANGLE, open_v);
    cfg_index_i <= CFG_CLOSE_ANGLE;
    cfg_data_i  <= close_v;
    @(posedge clk_i);
    sb.write_register(CFG_CLOSE_ANGLE, close_v);
    reg_writes += 2;
    if (spare_too) begin
      // Writes to unused indices must leave both angles alone.
      cfg_index_i <= CFG_SPARE_A;
      cfg_data_i  <= CFG_W'($urandom);
      @(posedge clk_i);
      cfg_index_i <= CFG_SPARE_B;
      cfg_data_i  <= CFG_W'($urandom);
      @(posedge clk_i);
      reg_writes += 2;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : result_sink
    valve_result_t got;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.command_angle    = out_if.command_angle;
        got.linear_position  = out_if.linear_position;
        got.section_estimate = out_if.section_estimate;
        sb.check_word(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Only result words that were expected count as progress, so a block that
  // keeps emitting without taking input still times out.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready && sb.pending() != 0)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("** valve_aperture_command_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = CFG_OPEN_ANGLE;
    cfg_data_i            = '0;
    in_if.valid           = 1'b0;
    in_if.opcode          = OP_QUERY;
    in_if.angle_request   = '0;
    in_if.section_request = '0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_left             = 0;
    reg_writes            = 0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset angles: reset state, field extremes, the
    // fit knee and the clamp edges, estimate boundaries and unused opcodes.
    send_word(OP_QUERY, 16'd0, 32'd0);
    send_word(OP_OPEN, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_CLOSE, 16'd0, 32'd0);
    send_word(OP_RAW, 16'd0, 32'd0);
    send_word(OP_RAW, 16'hFFFF, 32'd0);
    send_word(OP_RAW, 16'd105, 32'd0);
    send_word(OP_RAW, 16'd106, 32'd0);
    send_word(OP_RAW, 16'd50, 32'd0);
    send_word(OP_RAW, 16'd49, 32'd0);
    send_word(OP_SECTION, 16'd0, 32'h8000_0000);
    send_word(OP_SECTION, 16'd0, 32'h7FFF_FFFF);
    send_word(OP_SECTION, 16'd0, 32'd0);
    send_word(OP_SECTION, 16'd0, 32'd1959);
    send_word(OP_SECTION, 16'd0, 32'd1960);
    send_word(OP_SECTION, 16'd0, 32'd3318);
    send_word(OP_SECTION, 16'd0, 32'd3319);
    send_word(OP_LINEAR, 16'd0, 32'd0);
    send_word(OP_LINEAR, 16'hFFFF, 32'd0);
    send_word(OP_LINEAR, 16'd125, 32'd0);
    send_word(OP_LINEAR, 16'd60, 32'd0);
    send_word(OP_SPARE_A, 16'd7, 32'd0);
    send_word(OP_SPARE_B, 16'd7, 32'd0);
    send_word(OP_RAW, 16'd127, 32'd0);
    in_if.valid <= 1'b0;
    wait_drained();

    for (phase = 1; phase <= 6; phase++) begin
      case (phase)
        1: set_angles(7'd125, 7'd0, 1'b0);
        2: set_angles(7'd0, 7'd0, 1'b1);
        3: set_angles(7'd127, 7'd127, 1'b0);
        4: set_angles(CFG_W'($urandom), CFG_W'($urandom), 1'b1);
        5: set_angles(7'd30, 7'd90, 1'b0);
        default: set_angles(7'd0, 7'd125, 1'b0);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      // The result side goes quiet for a long stretch while words keep
      // coming, so the block fills and must stall its input.
      if (phase == 2) hold_left = 400;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 4 && n == 60) begin
          in_if.valid <= 1'b0;
          wait_drained();
        end
        send_random_word();
      end
      in_if.valid <= 1'b0;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d request words (%0d section, %0d linear, %0d raw) across six angle",
             sb.noted, sb.op_count[OP_SECTION], sb.op_count[OP_LINEAR], sb.op_count[OP_RAW]);
    $display("settings with %0d register writes; %0d result words checked, %0d mismatches.",
             reg_writes, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** valve_aperture_command_unit: PASSED **");
    end else begin
      $display("** valve_aperture_command_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/vacu_pkg.sv
rtl/vacu_if.sv
rtl/vacu_serial_alu.sv
rtl/vacu_section_seq.sv
rtl/valve_aperture_command_unit.sv
verif/valve_aperture_command_unit_tb.sv
